// ----- hw/rtl/m61mp_pkg.sv -----
// Shared types, constants and the fold function for the modular power block.
package m61mp_pkg;

  localparam int WORD_W = 64;
  localparam int RES_W  = 61;
  localparam int HALF_W = 31;
  localparam int PROD_W = 2 * HALF_W;

  // The Mersenne prime 2^61 - 1.
  localparam logic [RES_W-1:0] PRIME = {RES_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACC_WAIT,
    ST_SQ_WAIT,
    ST_DONE
  } state_t;

  // Fold any 64-bit value below the prime, using 2^61 == 1.
  function automatic logic [RES_W-1:0] fold64(input logic [WORD_W-1:0] v);
    logic [RES_W:0] s;
    s = {{(RES_W-2){1'b0}}, v[WORD_W-1:RES_W]} + {1'b0, v[RES_W-1:0]};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[RES_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/m61mp_mulmod.sv -----
// Iterative modular multiplier: one 31x31 multiplier over four partial products.
module m61mp_mulmod import m61mp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RES_W-1:0] a,
  input  logic [RES_W-1:0] b,
  output logic             done,
  output logic [RES_W-1:0] product
);

  localparam logic [2:0] STEP_ISSUE_END = 3'd4;
  localparam logic [2:0] STEP_FOLD      = 3'd5;

  localparam logic [1:0] KIND_LOW  = 2'd0;
  localparam logic [1:0] KIND_HIGH = 2'd1;
  localparam logic [1:0] KIND_MIDA = 2'd2;
  localparam logic [1:0] KIND_MIDB = 2'd3;

  logic              busy;
  logic [2:0]        step;
  logic [RES_W-1:0]  opa;
  logic [RES_W-1:0]  opb;
  logic [PROD_W-1:0] prod;
  logic [1:0]        prod_kind;
  logic [WORD_W-1:0] sum;

  logic [HALF_W-1:0] mul_x;
  logic [HALF_W-1:0] mul_y;
  logic [PROD_W-1:0] mul_full;
  logic [WORD_W-1:0] weighted;

  // Pick the operand halves for the partial product of this step.
  always_comb begin
    unique case (step[1:0])
      KIND_LOW: begin
        mul_x = opa[HALF_W-1:0];
        mul_y = opb[HALF_W-1:0];
      end
      KIND_HIGH: begin
        mul_x = {1'b0, opa[RES_W-1:HALF_W]};
        mul_y = {1'b0, opb[RES_W-1:HALF_W]};
      end
      KIND_MIDA: begin
        mul_x = {1'b0, opa[RES_W-1:HALF_W]};
        mul_y = opb[HALF_W-1:0];
      end
      KIND_MIDB: begin
        mul_x = opa[HALF_W-1:0];
        mul_y = {1'b0, opb[RES_W-1:HALF_W]};
      end
    endcase
  end

  assign mul_full = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};

  // Weight the registered product: 2^62 == 2 and 2^61 == 1 modulo the prime.
  always_comb begin
    unique case (prod_kind)
      KIND_LOW:  weighted = {2'b00, prod};
      KIND_HIGH: weighted = {1'b0, prod, 1'b0};
      KIND_MIDA, KIND_MIDB: begin
        weighted = {32'd0, prod[PROD_W-1:30]} + {3'd0, prod[29:0], 31'd0};
      end
    endcase
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        if (step == STEP_FOLD) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  // Datapath: issue a product, accumulate the previous one, fold at the end.
  always_ff @(posedge clk) begin
    if (start) begin
      opa <= a;
      opb <= b;
      sum <= '0;
    end else if (busy) begin
      if (step < STEP_ISSUE_END) begin
        prod      <= mul_full;
        prod_kind <= step[1:0];
      end
      if (step != 3'd0 && step <= STEP_ISSUE_END) begin
        sum <= sum + weighted;
      end
      if (step == STEP_FOLD) begin
        product <= fold64(sum);
      end
    end
  end

endmodule

// ----- hw/rtl/mersenne61_modular_power.sv -----
// Top level: square-and-multiply exponentiation modulo 2^61 - 1.
//
// An item on the input channel carries a 64-bit base and a 64-bit exponent;
// the output channel returns one 61-bit result, base^exponent mod 2^61 - 1.
// Both channels use valid and ready. The block takes one item at a time:
// in_ready is high only while no item is in work or waiting to be taken.
// The exponent is scanned from its least significant bit. Each modular
// multiply runs on one shared unit with a single 31x31 multiplier: four
// partial products, one last add, one fold and one handoff. A zero
// exponent gives 1.
// The result is held in a register; if the receiver stalls, out_valid and
// power_result stay put until out_ready, and no new item is taken meanwhile.
// A synchronous reset returns the block to idle and drops any item in work.
module mersenne61_modular_power import m61mp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] base_value,
  input  logic [WORD_W-1:0] exponent_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RES_W-1:0]  power_result
);

  state_t            state;
  state_t            state_next;
  logic [RES_W-1:0]  acc;
  logic [RES_W-1:0]  sq;
  logic [WORD_W-1:0] e;

  logic              mul_start;
  logic [RES_W-1:0]  mul_a;
  logic [RES_W-1:0]  mul_b;
  logic              mul_done;
  logic [RES_W-1:0]  mul_product;

  m61mp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier requests.
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = sq;
    mul_b      = sq;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (e == '0) begin
          state_next = ST_DONE;
        end else if (e[0]) begin
          mul_start  = 1'b1;
          mul_a      = acc;
          state_next = ST_ACC_WAIT;
        end else begin
          mul_start  = 1'b1;
          state_next = ST_SQ_WAIT;
        end
      end
      ST_ACC_WAIT: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          state_next = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: begin
        if (mul_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Working registers: accumulator, running square and remaining exponent.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      acc <= {{(RES_W-1){1'b0}}, 1'b1};
      sq  <= fold64(base_value);
      e   <= exponent_value;
    end else if (state == ST_ACC_WAIT && mul_done) begin
      acc <= mul_product;
    end else if (state == ST_SQ_WAIT && mul_done) begin
      sq <= mul_product;
      e  <= {1'b0, e[WORD_W-1:1]};
    end
  end

  assign in_ready     = (state == ST_IDLE);
  assign out_valid    = (state == ST_DONE);
  assign power_result = acc;

  // The multiplier reports completion only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_ACC_WAIT || state == ST_SQ_WAIT))
    else $error("multiplier finished outside a wait state");

  // A result shown on the output is fully reduced.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (power_result != PRIME))
    else $error("result not reduced below the prime");

  // An accepted item goes straight to the exponent check.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_CHECK))
    else $error("accepted item did not start work");

  // A new multiply is never requested while waiting on one still running.
  assert property (@(posedge clk) disable iff (rst)
    (mul_start && (state == ST_ACC_WAIT || state == ST_SQ_WAIT)) |-> mul_done)
    else $error("multiplier restarted before it finished");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the modular power block modulo 2^61 - 1.
module tb_top import m61mp_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned SETTLE_CYCLES = 1000;
  localparam logic [127:0] MODULUS = {{(128-RES_W){1'b0}}, PRIME};

  // One accepted item together with the power it must produce.
  typedef struct {
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] exponent;
    logic [RES_W-1:0]  power;
  } power_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [WORD_W-1:0] base_value = '0;
  logic [WORD_W-1:0] exponent_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [RES_W-1:0]  power_result;

  power_item_t       expected_powers[$];
  power_item_t       oldest_power;
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;

  mersenne61_modular_power i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .base_value     (base_value),
    .exponent_value (exponent_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .power_result   (power_result)
  );

  // Free-running clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mersenne61_modular_power test failed");
      $finish;
    end
  end

  // Receiver side: drop ready at random with the current idle rate.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Compare each returned power with the oldest outstanding item.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected power_result %h with no item outstanding",
                 $time, power_result);
        error_count++;
      end else begin
        oldest_power = expected_powers.pop_front();
        if (power_result !== oldest_power.power) begin
          $display("%0t: power_result mismatch for base %h exponent %h: expected %h, actual %h",
                   $time, oldest_power.base, oldest_power.exponent,
                   oldest_power.power, power_result);
          error_count++;
        end
      end
    end
  end

  // Square-and-multiply with exact 128-bit products reduced modulo the prime.
  function automatic logic [RES_W-1:0] power_mod_prime(input logic [WORD_W-1:0] base,
                                                        input logic [WORD_W-1:0] exponent);
    logic [127:0] acc;
    logic [127:0] square;
    acc = 128'd1;
    square = {64'd0, base} % MODULUS;
    for (int i = 0; i < WORD_W; i++) begin
      if (exponent[i]) begin
        acc = (acc * square) % MODULUS;
      end
      square = (square * square) % MODULUS;
    end
    return acc[RES_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offer one item, with an optional random gap first, and record its power
  // once the block takes it. Valid stays high on return so back-to-back items
  // do not toggle it within one time step.
  task automatic send_item(input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] exponent);
    power_item_t item;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    base_value     <= base;
    exponent_value <= exponent;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item.base     = base;
    item.exponent = exponent;
    item.power    = power_mod_prime(base, exponent);
    expected_powers.push_back(item);
  endtask

  // Stop offering items until every outstanding power has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
  endtask

  // A zero exponent gives 1 for any base, zero and multiples of the prime too.
  task automatic test_zero_exponent();
    send_item(64'd0, 64'd0);
    send_item({3'b000, PRIME}, 64'd0);
    send_item({64{1'b1}}, 64'd0);
    send_item(rand_word(), 64'd0);
  endtask

  // Bases at or above the prime are reduced before use; a zero base is covered too.
  task automatic test_base_reduction();
    send_item({3'b000, PRIME}, 64'd1);
    send_item({3'b000, PRIME} * 64'd2, 64'd5);
    send_item({3'b000, PRIME} * 64'd7, {64{1'b1}});
    send_item({3'b000, PRIME} + 64'd1, {64{1'b1}});
    send_item({64{1'b1}}, 64'd1);
    send_item({64{1'b1}}, rand_word());
    send_item(64'd0, 64'd1);
    send_item(64'd0, {64{1'b1}});
  endtask

  // Exponent extremes and a few identities of the prime field.
  task automatic test_exponent_extremes();
    send_item(64'd2, 64'd1);
    send_item(64'd2, 64'd61);
    send_item({3'b000, PRIME} - 64'd1, {64{1'b1}});
    send_item({3'b000, PRIME} - 64'd1, 64'd2);
    send_item(rand_word(), 64'h8000_0000_0000_0000);
    send_item(rand_word(), {64{1'b1}});
    send_item(64'd3, {3'b000, PRIME} - 64'd1);
    send_item(64'd5, {3'b000, PRIME} - 64'd2);
    send_item(64'd1, rand_word());
  endtask

  // Random items; exponent lengths are spread evenly from zero to the full
  // width, so every exponent bit still gets exercised.
  task automatic test_random(input int unsigned count);
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] exponent;
    int unsigned       exp_len;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(0, 15))
        0:       base = {3'b000, PRIME} * WORD_W'($urandom_range(0, 8));
        1:       base = {3'b000, PRIME} - WORD_W'($urandom_range(0, 2));
        2:       base = {64{1'b1}} - WORD_W'($urandom_range(0, 3));
        3:       base = WORD_W'($urandom_range(0, 3));
        default: base = rand_word();
      endcase
      exp_len = $urandom_range(0, WORD_W);
      if (exp_len == 0) begin
        exponent = '0;
      end else if (exp_len == WORD_W) begin
        exponent = rand_word() | (64'd1 << (WORD_W - 1));
      end else begin
        exponent = (rand_word() & ((64'd1 << exp_len) - 64'd1)) | (64'd1 << (exp_len - 1));
      end
      send_item(base, exponent);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sender mostly busy, receiver mostly stalled.
    tx_idle_pct = 8;
    rx_idle_pct = 85;
    test_zero_exponent();
    test_base_reduction();
    test_exponent_extremes();
    test_random(420);
    wait_for_drain();

    // Sender mostly idle, receiver mostly ready.
    tx_idle_pct = 85;
    rx_idle_pct = 8;
    test_random(420);
    wait_for_drain();

    // No idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(410);
    wait_for_drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("mersenne61_modular_power test passed");
    end else begin
      $display("mersenne61_modular_power test failed");
    end
    $finish;
  end

endmodule
